### rtl/c2bd_pkg.sv
// c2bd_pkg: shared constants, pipeline word type and arctangent table for
// the bearing/distance pipeline. No dependencies.
package c2bd_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_FRAC_BITS = 6;

   localparam int ACC_FRAC    = 20;
   localparam int GUARD_BITS  = 60 - COORD_WIDTH;
   localparam int UV_W        = COORD_WIDTH + GUARD_BITS + 3;
   localparam int Z_W         = ACC_FRAC + 11;
   localparam int SQ_W        = 2 * COORD_WIDTH;
   localparam int SQRT_STEPS  = COORD_WIDTH;
   localparam int NUM_CELLS   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
   localparam int IDX_W       = $clog2(NUM_CELLS);
   localparam int ATAN_IDX_W  = 5;
   localparam int DIST_W      = 16;
   localparam int BEARING_W   = 16;
   localparam int ANGLE_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int LATENCY     = NUM_CELLS + 3;

   localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180) << ACC_FRAC;
   localparam logic signed [Z_W-1:0] Z_ROUND     = Z_W'(1) << (ANGLE_SHIFT - 1);

   localparam logic [BEARING_W-1:0] BEAR_EAST  = BEARING_W'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [BEARING_W-1:0] BEAR_WEST  = BEARING_W'(-(90 * (2 ** ANGLE_FRAC_BITS)));
   localparam logic [BEARING_W-1:0] BEAR_SOUTH = BEARING_W'(180 * (2 ** ANGLE_FRAC_BITS));

   typedef struct packed {
      logic origin;
      logic y_zero;
      logic x_zero;
      logic x_pos;
      logic y_pos;
   } flags_type;

   typedef struct packed {
      flags_type               flags;
      logic signed [UV_W-1:0]  u;
      logic signed [UV_W-1:0]  v;
      logic signed [Z_W-1:0]   z;
      logic [SQ_W-1:0]         rem;
      logic [SQ_W-1:0]         root;
   } cell_data_type;

   // atan(2^-i) in degrees, 20 fraction bits
   function automatic logic signed [Z_W-1:0] atan_q(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = Z_W'(47185920);
         5'd1:    val = Z_W'(27855475);
         5'd2:    val = Z_W'(14718068);
         5'd3:    val = Z_W'(7471121);
         5'd4:    val = Z_W'(3750058);
         5'd5:    val = Z_W'(1876857);
         5'd6:    val = Z_W'(938658);
         5'd7:    val = Z_W'(469357);
         5'd8:    val = Z_W'(234682);
         5'd9:    val = Z_W'(117342);
         5'd10:   val = Z_W'(58671);
         5'd11:   val = Z_W'(29335);
         5'd12:   val = Z_W'(14668);
         5'd13:   val = Z_W'(7334);
         5'd14:   val = Z_W'(3667);
         5'd15:   val = Z_W'(1833);
         5'd16:   val = Z_W'(917);
         5'd17:   val = Z_W'(458);
         5'd18:   val = Z_W'(229);
         5'd19:   val = Z_W'(115);
         5'd20:   val = Z_W'(57);
         5'd21:   val = Z_W'(29);
         5'd22:   val = Z_W'(14);
         5'd23:   val = Z_W'(7);
         5'd24:   val = Z_W'(4);
         5'd25:   val = Z_W'(2);
         5'd26:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/c2bd_front.sv
// c2bd_front: two-stage entry of the pipeline; squares, sums and sets up the
// rotation start point. Depends on c2bd_pkg.
module c2bd_front
   import c2bd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [COORD_WIDTH-1:0]  pos_x,
   input  logic signed [COORD_WIDTH-1:0]  pos_y,
   output logic                           out_valid,
   output cell_data_type                  out_data
);

   logic signed [UV_W-1:0]  x_ext;
   logic signed [UV_W-1:0]  y_ext;
   logic [COORD_WIDTH-1:0]  abs_x;
   logic [COORD_WIDTH-1:0]  abs_y;
   logic                    y_neg;
   cell_data_type           s1_data_in;
   logic [SQ_W-1:0]         sqx_in;
   logic [SQ_W-1:0]         sqy_in;

   logic                    s1_valid_ff;
   cell_data_type           s1_data_ff;
   logic [SQ_W-1:0]         s1_sqx_ff;
   logic [SQ_W-1:0]         s1_sqy_ff;
   logic                    s2_valid_ff;
   cell_data_type           s2_data_ff;
   cell_data_type           s2_data_in;

   assign x_ext = UV_W'(pos_x);
   assign y_ext = UV_W'(pos_y);
   assign y_neg = pos_y[COORD_WIDTH-1];
   assign abs_x = pos_x[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_x) : COORD_WIDTH'(pos_x);
   assign abs_y = y_neg ? COORD_WIDTH'(-pos_y) : COORD_WIDTH'(pos_y);
   assign sqx_in = SQ_W'(abs_x) * SQ_W'(abs_x);
   assign sqy_in = SQ_W'(abs_y) * SQ_W'(abs_y);

   always_comb begin
      s1_data_in              = '0;
      s1_data_in.flags.origin = (pos_x == '0) && (pos_y == '0);
      s1_data_in.flags.y_zero = (pos_y == '0);
      s1_data_in.flags.x_zero = (pos_x == '0);
      s1_data_in.flags.x_pos  = !pos_x[COORD_WIDTH-1] && (pos_x != '0);
      s1_data_in.flags.y_pos  = !y_neg && (pos_y != '0);
      if (y_neg) begin
         s1_data_in.u = (-y_ext) <<< GUARD_BITS;
         s1_data_in.v = (-x_ext) <<< GUARD_BITS;
         s1_data_in.z = Z_HALF_TURN;
      end else begin
         s1_data_in.u = y_ext <<< GUARD_BITS;
         s1_data_in.v = x_ext <<< GUARD_BITS;
         s1_data_in.z = '0;
      end
   end

   always_comb begin
      s2_data_in      = s1_data_ff;
      s2_data_in.rem  = s1_sqx_ff + s1_sqy_ff;
      s2_data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_sqx_ff  <= sqx_in;
      s1_sqy_ff  <= sqy_in;
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

### rtl/c2bd_cell.sv
// c2bd_cell: one link of the chain; one vectoring rotation and one
// square-root digit per word. Depends on c2bd_pkg.
module c2bd_cell
   import c2bd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  stage_idx,
   input  logic              in_valid,
   input  cell_data_type     in_data,
   output logic              out_valid,
   output cell_data_type     out_data
);

   logic                    cordic_on;
   logic                    sqrt_on;
   logic signed [UV_W-1:0]  u_cur;
   logic signed [UV_W-1:0]  v_cur;
   logic signed [UV_W-1:0]  du;
   logic signed [UV_W-1:0]  dv;
   logic signed [Z_W-1:0]   angle;
   logic [SQ_W:0]           sq_bit;
   logic [SQ_W:0]           trial;
   int                      bit_pos;
   cell_data_type           data_in;

   logic                    valid_ff;
   cell_data_type           data_ff;

   assign cordic_on = int'(stage_idx) < CORDIC_STAGES;
   assign sqrt_on   = int'(stage_idx) < SQRT_STEPS;
   assign u_cur     = in_data.u;
   assign v_cur     = in_data.v;
   assign du        = v_cur >>> stage_idx;
   assign dv        = u_cur >>> stage_idx;
   assign angle     = atan_q(ATAN_IDX_W'(stage_idx));

   always_comb begin
      bit_pos = sqrt_on ? (SQ_W - 2 - 2 * int'(stage_idx)) : 0;
      sq_bit  = sqrt_on ? ((SQ_W + 1)'(1) << bit_pos) : '0;
      trial   = {1'b0, in_data.root} + sq_bit;
   end

   always_comb begin
      data_in = in_data;
      if (cordic_on) begin
         if (!v_cur[UV_W-1]) begin
            data_in.u = u_cur + du;
            data_in.v = v_cur - dv;
            data_in.z = in_data.z + angle;
         end else begin
            data_in.u = u_cur - du;
            data_in.v = v_cur + dv;
            data_in.z = in_data.z - angle;
         end
      end
      if (sqrt_on) begin
         if ({1'b0, in_data.rem} >= trial) begin
            data_in.rem  = in_data.rem - trial[SQ_W-1:0];
            data_in.root = (in_data.root >> 1) + sq_bit[SQ_W-1:0];
         end else begin
            data_in.root = in_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/c2bd_back.sv
// c2bd_back: rounds angle and root, applies axis and origin cases and holds
// the result word. Depends on c2bd_pkg.
module c2bd_back
   import c2bd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cell_data_type         in_data,
   output logic                  out_valid,
   output logic [DIST_W-1:0]     dist_mag,
   output logic [BEARING_W-1:0]  bearing_deg,
   output logic                  at_origin
);

   logic signed [Z_W-1:0]   round_z;
   logic signed [Z_W-1:0]   scaled_z;
   logic [SQ_W-1:0]         dist_full;
   logic [BEARING_W-1:0]    bearing_in;

   logic                    valid_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [BEARING_W-1:0]    bearing_ff;
   logic                    origin_ff;

   assign round_z   = in_data.z + Z_ROUND;
   assign scaled_z  = round_z >>> ANGLE_SHIFT;
   assign dist_full = in_data.root + SQ_W'(in_data.rem > in_data.root);

   always_comb begin
      if (in_data.flags.origin) begin
         bearing_in = '0;
      end else if (in_data.flags.y_zero) begin
         bearing_in = in_data.flags.x_pos ? BEAR_EAST : BEAR_WEST;
      end else if (in_data.flags.x_zero) begin
         bearing_in = in_data.flags.y_pos ? '0 : BEAR_SOUTH;
      end else begin
         bearing_in = scaled_z[BEARING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff    <= dist_full[DIST_W-1:0];
      bearing_ff <= bearing_in;
      origin_ff  <= in_data.flags.origin;
   end

   assign out_valid   = valid_ff;
   assign dist_mag    = dist_ff;
   assign bearing_deg = bearing_ff;
   assign at_origin   = origin_ff;

endmodule

### rtl/cartesian_to_bearing_distance.sv
// cartesian_to_bearing_distance: top level, front end, chain of cells, back end.
// Depends on c2bd_pkg, c2bd_front, c2bd_cell, c2bd_back.
//
//   channel   ports                                         handshake
//   request   req_pos_x, req_pos_y                          start & !busy
//   response  rsp_dist_mag, rsp_bearing_deg, rsp_at_origin  rsp_valid, one cycle
//
// one word per clock; each word passes through two entry stages, one cell
// per rotation and square-root digit, and one output register. busy stays
// low, so start is taken in every cycle. reset clears the valid bits along
// the chain only; words in flight are dropped. the receiver cannot stall: a
// result is shown for exactly one cycle.
module cartesian_to_bearing_distance
   import c2bd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [COORD_WIDTH-1:0]  req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]  req_pos_y,
   output logic                           rsp_valid,
   output logic [DIST_W-1:0]              rsp_dist_mag,
   output logic signed [BEARING_W-1:0]    rsp_bearing_deg,
   output logic                           rsp_at_origin
);

   logic           chain_valid [0:NUM_CELLS];
   cell_data_type  chain_data  [0:NUM_CELLS];
   logic [BEARING_W-1:0] bearing_raw;

   assign busy = 1'b0;

   c2bd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      c2bd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IDX_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   c2bd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[NUM_CELLS]),
      .in_data     (chain_data[NUM_CELLS]),
      .out_valid   (rsp_valid),
      .dist_mag    (rsp_dist_mag),
      .bearing_deg (bearing_raw),
      .at_origin   (rsp_at_origin)
   );

   assign rsp_bearing_deg = bearing_raw;

endmodule

### rtl/c2bd_checker.sv
// c2bd_checker: port-level checks on latency and the origin case, bound to
// the top level. Depends on c2bd_pkg.
module c2bd_checker
   import c2bd_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic signed [COORD_WIDTH-1:0]  req_pos_x,
   input logic signed [COORD_WIDTH-1:0]  req_pos_y,
   input logic                           rsp_valid,
   input logic [DIST_W-1:0]              rsp_dist_mag,
   input logic signed [BEARING_W-1:0]    rsp_bearing_deg,
   input logic                           rsp_at_origin
);

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not come out on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result word without a request");

   a_origin_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_at_origin == $past((req_pos_x == '0) && (req_pos_y == '0), LATENCY)))
      else $error("origin flag does not match request");

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_origin) |-> ((rsp_dist_mag == '0) && (rsp_bearing_deg == '0)))
      else $error("origin result not zero");

endmodule

bind cartesian_to_bearing_distance c2bd_checker u_c2bd_checker (.*);
